// ===== rtl/core/brae_pkg.sv =====
package brae_pkg;

  localparam int FIELD_W   = 11;
  localparam int VALUE_W   = 32;
  localparam int RESULT_W  = 64;
  localparam int OPC_W     = 3;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [OPC_W-1:0] {
    OPC_LOAD_ELEM = 3'd0,
    OPC_LOAD_OP   = 3'd1,
    OPC_QUERY     = 3'd2,
    OPC_COMPUTE   = 3'd3,
    OPC_READ      = 3'd4
  } opcode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OP_COUNT     = 2'd1;

  // One range-add operation as it sits in the operation memory.
  typedef struct packed {
    logic [FIELD_W-1:0] left;
    logic [FIELD_W-1:0] right;
    logic [VALUE_W-1:0] amount;
  } op_entry_t;

  typedef struct packed {
    logic clr;
    logic step;
  } mac_ctl_t;

  typedef struct packed {
    logic                skip;
    logic [FIELD_W-1:0]  lo;
    logic [FIELD_W-1:0]  hi;
    logic [RESULT_W-1:0] add;
  } mac_res_t;

  // A written value of zero counts as one; anything above the limit saturates.
  function automatic logic [FIELD_W-1:0] clamp_cfg(input logic [FIELD_W-1:0] v,
                                                   input logic [FIELD_W-1:0] lim);
    logic [FIELD_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = FIELD_W'(1);
    end else if (v > lim) begin
      r = lim;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/brae_ifs.sv =====
interface brae_item_if;
  import brae_pkg::*;

  logic               valid;
  logic               ready;
  logic [OPC_W-1:0]   opcode;
  logic [FIELD_W-1:0] slot_index;
  logic [FIELD_W-1:0] range_left;
  logic [FIELD_W-1:0] range_right;
  logic [VALUE_W-1:0] element_value;
  logic [VALUE_W-1:0] op_amount;

  modport source (output valid, opcode, slot_index, range_left, range_right,
                  element_value, op_amount, input ready);
  modport sink (input valid, opcode, slot_index, range_left, range_right,
                element_value, op_amount, output ready);
endinterface

interface brae_result_if;
  import brae_pkg::*;

  logic                valid;
  logic                ready;
  logic [RESULT_W-1:0] result_value;
  logic [FIELD_W-1:0]  result_index;

  modport source (output valid, result_value, result_index, input ready);
  modport sink (input valid, result_value, result_index, output ready);
endinterface

interface brae_cfg_if;
  import brae_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [FIELD_W-1:0]   write_data;

  modport source (output valid, reg_index, write_data, input ready);
  modport sink (input valid, reg_index, write_data, output ready);
endinterface

// ===== rtl/core/brae_op_mac.sv =====
module brae_op_mac (
  input  logic                         clk,
  input  logic                         rst,
  input  brae_pkg::mac_ctl_t           ctl,
  input  logic [brae_pkg::VALUE_W-1:0] rep_diff,
  input  brae_pkg::op_entry_t          op,
  input  logic [brae_pkg::FIELD_W-1:0] len,
  output brae_pkg::mac_res_t           res
);
  import brae_pkg::*;

  logic [VALUE_W-1:0] cnt;
  logic               step_q;
  logic [VALUE_W-1:0] s1_amount;
  logic [FIELD_W-1:0] s1_lo;
  logic [FIELD_W-1:0] s1_hi;
  logic               s1_skip;
  logic [FIELD_W-1:0] hi_c;
  logic               skip_c;

  // The element range ends at the array length; an empty range adds nothing.
  always_comb begin
    hi_c   = (op.right > len) ? len : op.right;
    skip_c = (op.left == '0) || (op.left > hi_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      step_q <= 1'b0;
    end else begin
      step_q <= ctl.step;
      if (ctl.clr) begin
        cnt <= '0;
      end else if (ctl.step) begin
        cnt <= cnt + rep_diff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      s1_amount <= op.amount;
      s1_lo     <= op.left;
      s1_hi     <= hi_c;
      s1_skip   <= skip_c;
    end
    if (step_q) begin
      res.add  <= s1_amount * cnt;
      res.lo   <= s1_lo;
      res.hi   <= s1_hi;
      res.skip <= s1_skip;
    end
  end

endmodule

// ===== rtl/core/batched_range_add_engine_core.sv =====
// Load items may arrive back to back. A query performs two read-modify-writes of the
// repeat-count memory. A read passes through S_READ before its result is registered.
// A compute walks the elements, then the operation slots, then the elements again, bound
// by the single element memory. Reset clears control state and then zeroes the
// repeat-count memory; no item transaction is taken then, but configuration always is.
module batched_range_add_engine_core #(
  parameter int MAX_LEN = 1024,
  parameter int MAX_OPS = 1024
) (
  input logic          clk,
  input logic          rst,
  brae_item_if.sink    items,
  brae_result_if.source results,
  brae_cfg_if.sink     cfg
);
  import brae_pkg::*;

  // Element memory holds 0..MAX_LEN. The term that the difference array would place just
  // past the last element is dropped, since the prefix walk never reaches it, so elements
  // beyond the array length keep their values. The repeat-count memory has one extra entry
  // for the closing term of a query that ends at the last slot.
  localparam int LEN_AW    = $clog2(MAX_LEN + 2);
  localparam int OP_AW     = $clog2(MAX_OPS + 2);
  localparam int LEN_CW    = (LEN_AW > FIELD_W) ? LEN_AW : FIELD_W;
  localparam int OP_CW     = (OP_AW > FIELD_W) ? OP_AW : FIELD_W;
  localparam int LEN_LIMIT = (MAX_LEN < 2047) ? MAX_LEN : 2047;
  localparam int OPS_LIMIT = (MAX_OPS < 2047) ? MAX_OPS : 2047;
  localparam int LEN_RESET = (MAX_LEN < 1024) ? MAX_LEN : 1024;
  localparam int OPS_RESET = (MAX_OPS < 1024) ? MAX_OPS : 1024;
  localparam logic [OP_AW-1:0] CLR_LAST = OP_AW'(MAX_OPS + 1);

  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_READ   = 13'b0000000000100,
    S_QLO    = 13'b0000000001000,
    S_QHI    = 13'b0000000010000,
    S_DIFF   = 13'b0000000100000,
    S_OPRD   = 13'b0000001000000,
    S_OPMAC  = 13'b0000010000000,
    S_OPMUL  = 13'b0000100000000,
    S_OPLO   = 13'b0001000000000,
    S_OPLOW  = 13'b0010000000000,
    S_OPHIW  = 13'b0100000000000,
    S_PREFIX = 13'b1000000000000
  } state_t;

  state_t state;

  // Memories. Each has one write port and one registered read port.
  logic [RESULT_W-1:0] elem_mem [MAX_LEN:0];
  op_entry_t           op_mem   [MAX_OPS:0];
  logic [VALUE_W-1:0]  rep_mem  [MAX_OPS+1:0];

  logic                elem_we, elem_re;
  logic [LEN_AW-1:0]   elem_wa, elem_ra;
  logic [RESULT_W-1:0] elem_wd, elem_q;
  logic                op_we, op_re;
  logic [OP_AW-1:0]    op_wa;
  op_entry_t           op_wd, op_q;
  logic                rep_we, rep_re;
  logic [OP_AW-1:0]    rep_wa, rep_ra;
  logic [VALUE_W-1:0]  rep_wd, rep_q;

  // Configuration registers.
  logic [FIELD_W-1:0] len_reg;
  logic [FIELD_W-1:0] ops_reg;

  // Sequencing registers.
  logic [OP_AW-1:0]    clr_i;
  logic [OP_AW-1:0]    op_i;
  logic [LEN_AW-1:0]   elem_i;
  logic [LEN_AW-1:0]   elem_wi;
  logic                pend;
  logic [RESULT_W-1:0] run;
  logic [OP_AW-1:0]    q_lo;
  logic [OP_AW-1:0]    q_hi;
  logic [FIELD_W-1:0]  res_idx;
  logic                res_zero;

  // Output register with one skid entry behind it.
  logic                out_valid;
  logic [RESULT_W-1:0] out_value;
  logic [FIELD_W-1:0]  out_index;
  logic                skid_valid;
  logic [RESULT_W-1:0] skid_value;
  logic [FIELD_W-1:0]  skid_index;

  mac_ctl_t mac_ctl;
  mac_res_t mac_res;

  logic                in_fire;
  logic                elem_in_range;
  logic                op_in_range;
  logic [OP_CW-1:0]    q_right_sat;
  logic                q_ok;
  logic                walk;
  logic                walk_more;
  logic                op_last;
  logic [LEN_AW-1:0]   mac_hi1;
  logic                hi1_in;
  logic [RESULT_W-1:0] rd_val;
  logic                out_take_new;
  logic                skid_take_new;
  logic                out_take_skid;

  brae_op_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mac_ctl),
    .rep_diff (rep_q),
    .op       (op_q),
    .len      (len_reg),
    .res      (mac_res)
  );

  // Items are taken only between multi-cycle operations and while the skid entry is free.
  assign items.ready = (state == S_IDLE) && !skid_valid;
  assign in_fire     = items.valid && items.ready;
  assign cfg.ready   = 1'b1;

  assign elem_in_range = (items.slot_index != '0) &&
                         (LEN_CW'(items.slot_index) <= LEN_CW'(len_reg));
  assign op_in_range   = (items.slot_index != '0) &&
                         (OP_CW'(items.slot_index) <= OP_CW'(ops_reg));

  // A query's right end saturates at MAX_OPS; an empty or zero-based query is dropped.
  assign q_right_sat = (OP_CW'(items.range_right) > OP_CW'(MAX_OPS)) ?
                       OP_CW'(MAX_OPS) : OP_CW'(items.range_right);
  assign q_ok        = (items.range_left != '0) &&
                       (OP_CW'(items.range_left) <= q_right_sat);

  assign walk      = (state == S_DIFF) || (state == S_PREFIX);
  assign walk_more = LEN_CW'(elem_i) <= LEN_CW'(len_reg);
  assign op_last   = OP_CW'(op_i) >= OP_CW'(ops_reg);
  assign mac_hi1   = LEN_AW'(mac_res.hi) + LEN_AW'(1);
  // The closing term of an operation only lands when it falls inside the array.
  assign hi1_in    = LEN_CW'(mac_hi1) <= LEN_CW'(len_reg);

  // Memory port control. The element memory sees at most one write and one read a cycle,
  // and a read never targets the entry written in the same cycle.
  always_comb begin
    elem_we = 1'b0;
    elem_wa = '0;
    elem_wd = '0;
    elem_re = 1'b0;
    elem_ra = '0;
    op_we   = 1'b0;
    op_wa   = '0;
    op_wd   = '0;
    op_re   = 1'b0;
    rep_we  = 1'b0;
    rep_wa  = '0;
    rep_wd  = '0;
    rep_re  = 1'b0;
    rep_ra  = '0;
    mac_ctl = '{clr: 1'b0, step: 1'b0};
    unique case (state)
      S_CLEAR: begin
        rep_we = 1'b1;
        rep_wa = clr_i;
      end
      S_IDLE: begin
        if (in_fire) begin
          case (items.opcode)
            OPC_LOAD_ELEM: begin
              elem_we = elem_in_range;
              elem_wa = LEN_AW'(items.slot_index);
              elem_wd = {{(RESULT_W-VALUE_W){1'b0}}, items.element_value};
            end
            OPC_LOAD_OP: begin
              op_we = op_in_range;
              op_wa = OP_AW'(items.slot_index);
              op_wd = '{left: items.range_left, right: items.range_right,
                        amount: items.op_amount};
            end
            OPC_QUERY: begin
              rep_re = q_ok;
              rep_ra = OP_AW'(items.range_left);
            end
            OPC_COMPUTE: begin
              mac_ctl.clr = 1'b1;
            end
            OPC_READ: begin
              elem_re = elem_in_range;
              elem_ra = LEN_AW'(items.slot_index);
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
      end
      S_QLO: begin
        rep_we = 1'b1;
        rep_wa = q_lo;
        rep_wd = rep_q + VALUE_W'(1);
        rep_re = 1'b1;
        rep_ra = q_hi;
      end
      S_QHI: begin
        rep_we = 1'b1;
        rep_wa = q_hi;
        rep_wd = rep_q - VALUE_W'(1);
      end
      S_DIFF, S_PREFIX: begin
        if (pend) begin
          elem_we = 1'b1;
          elem_wa = elem_wi;
          elem_wd = (state == S_DIFF) ? (elem_q - run) : (run + elem_q);
        end
        if (walk_more) begin
          elem_re = 1'b1;
          elem_ra = elem_i;
        end
      end
      S_OPRD: begin
        op_re  = 1'b1;
        rep_re = 1'b1;
        rep_ra = op_i;
      end
      S_OPMAC: begin
        mac_ctl.step = 1'b1;
      end
      S_OPMUL: begin
      end
      S_OPLO: begin
        elem_re = !mac_res.skip;
        elem_ra = LEN_AW'(mac_res.lo);
      end
      S_OPLOW: begin
        elem_we = 1'b1;
        elem_wa = LEN_AW'(mac_res.lo);
        elem_wd = elem_q + mac_res.add;
        elem_re = hi1_in;
        elem_ra = mac_hi1;
      end
      S_OPHIW: begin
        elem_we = hi1_in;
        elem_wa = mac_hi1;
        elem_wd = elem_q - mac_res.add;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (elem_we) begin
      elem_mem[elem_wa] <= elem_wd;
    end
    if (elem_re) begin
      elem_q <= elem_mem[elem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (op_we) begin
      op_mem[op_wa] <= op_wd;
    end
    if (op_re) begin
      op_q <= op_mem[op_i];
    end
  end

  always_ff @(posedge clk) begin
    if (rep_we) begin
      rep_mem[rep_wa] <= rep_wd;
    end
    if (rep_re) begin
      rep_q <= rep_mem[rep_ra];
    end
  end

  // Sequencer. A compute walks the elements once to form differences, then each operation
  // slot (repeat count, multiply, two element updates for a non-empty range), then the
  // elements again to form prefix sums, and finally zeroes the repeat-count memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_i   <= '0;
      pend    <= 1'b0;
      len_reg <= FIELD_W'(LEN_RESET);
      ops_reg <= FIELD_W'(OPS_RESET);
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.reg_index)
          CFG_ARRAY_LENGTH: len_reg <= clamp_cfg(cfg.write_data, FIELD_W'(LEN_LIMIT));
          CFG_OP_COUNT:     ops_reg <= clamp_cfg(cfg.write_data, FIELD_W'(OPS_LIMIT));
          default: begin
          end
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          clr_i <= clr_i + OP_AW'(1);
          if (clr_i == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            case (items.opcode)
              OPC_QUERY: begin
                if (q_ok) begin
                  state <= S_QLO;
                end
              end
              OPC_COMPUTE: begin
                state  <= S_DIFF;
                elem_i <= LEN_AW'(1);
                op_i   <= OP_AW'(1);
                pend   <= 1'b0;
              end
              OPC_READ: begin
                state <= S_READ;
              end
              default: begin
              end
            endcase
          end
        end
        S_READ:  state <= S_IDLE;
        S_QLO:   state <= S_QHI;
        S_QHI:   state <= S_IDLE;
        S_DIFF, S_PREFIX: begin
          if (walk_more) begin
            elem_i <= elem_i + LEN_AW'(1);
            pend   <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              if (state == S_DIFF) begin
                state <= S_OPRD;
              end else begin
                state <= S_CLEAR;
                clr_i <= '0;
              end
            end
          end
        end
        S_OPRD:  state <= S_OPMAC;
        S_OPMAC: state <= S_OPMUL;
        S_OPMUL: state <= S_OPLO;
        S_OPLO: begin
          if (mac_res.skip) begin
            op_i <= op_i + OP_AW'(1);
            if (op_last) begin
              state  <= S_PREFIX;
              elem_i <= LEN_AW'(1);
              pend   <= 1'b0;
            end else begin
              state <= S_OPRD;
            end
          end else begin
            state <= S_OPLOW;
          end
        end
        S_OPLOW: state <= S_OPHIW;
        S_OPHIW: begin
          op_i <= op_i + OP_AW'(1);
          if (op_last) begin
            state  <= S_PREFIX;
            elem_i <= LEN_AW'(1);
            pend   <= 1'b0;
          end else begin
            state <= S_OPRD;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // Query and read payload taken on acceptance, and walk payload: the address of the pending
  // write and the running value. During the difference walk the running value is the
  // previous element; during the prefix walk it is the running sum.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      q_lo     <= OP_AW'(items.range_left);
      q_hi     <= OP_AW'(q_right_sat + OP_CW'(1));
      res_idx  <= items.slot_index;
      res_zero <= !elem_in_range;
    end
    if (walk) begin
      if (walk_more) begin
        elem_wi <= elem_i;
      end
      if (pend) begin
        run <= (state == S_DIFF) ? elem_q : (run + elem_q);
      end
    end else begin
      run <= '0;
    end
  end

  // Result delivery. A read lands in the output register when it is free or draining,
  // otherwise in the skid entry, which then refills the output register.
  assign rd_val        = res_zero ? '0 : elem_q;
  assign out_take_new  = (state == S_READ) && (!out_valid || results.ready);
  assign skid_take_new = (state == S_READ) && out_valid && !results.ready;
  assign out_take_skid = (state != S_READ) && out_valid && results.ready && skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_take_new) begin
        out_valid <= 1'b1;
      end else if (skid_take_new) begin
        skid_valid <= 1'b1;
      end else if (out_take_skid) begin
        skid_valid <= 1'b0;
      end else if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_take_new) begin
      out_value <= rd_val;
      out_index <= res_idx;
    end else if (out_take_skid) begin
      out_value <= skid_value;
      out_index <= skid_index;
    end
    if (skid_take_new) begin
      skid_value <= rd_val;
      skid_index <= res_idx;
    end
  end

  assign results.valid        = out_valid;
  assign results.result_value = out_value;
  assign results.result_index = out_index;

endmodule

// ===== rtl/core/brae_core_checker.sv =====
module brae_core_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [brae_pkg::OPC_W-1:0]    in_opcode,
  input logic [brae_pkg::FIELD_W-1:0]  in_slot_index,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [brae_pkg::RESULT_W-1:0] out_value,
  input logic [brae_pkg::FIELD_W-1:0]  out_index
);
  import brae_pkg::*;

  // A result held back by the sink stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_index))
    else $error("result changed while stalled");

  // A fresh result traces back to a read transaction accepted before it.
  a_read_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_opcode == OPC_READ, 2))
    else $error("result without a matching read");

  a_read_index: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> out_index == $past(in_slot_index, 2))
    else $error("result index does not match the read");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && $past(in_slot_index == '0, 2) |-> out_value == '0)
    else $error("read of index zero returned nonzero data");

  // A compute occupies the block, so items.ready drops once it is accepted.
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_opcode == OPC_COMPUTE |=> !in_ready)
    else $error("item taken right after a compute");

endmodule

bind batched_range_add_engine_core brae_core_checker u_brae_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (items.valid),
  .in_ready      (items.ready),
  .in_opcode     (items.opcode),
  .in_slot_index (items.slot_index),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .out_value     (results.result_value),
  .out_index     (results.result_index)
);

// ===== tb/tb_batched_range_add_engine_core.sv =====
module tb_batched_range_add_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  import brae_pkg::*;

  localparam int LEN_LIMIT      = 1024;
  localparam int OPS_LIMIT      = 1024;
  localparam int RANDOM_ITEMS   = 460;
  localparam int WATCHDOG_LIMIT = 50000;
  // Index 2 names no register; a write there must leave both registers alone.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;
  // Opcodes 5 to 7 carry no operation.
  localparam logic [OPC_W-1:0] OPC_SPARE_LO = 3'd5;
  localparam logic [OPC_W-1:0] OPC_SPARE_HI = 3'd7;

  typedef struct {
    logic [OPC_W-1:0]   opc;
    logic [FIELD_W-1:0] idx;
    logic [FIELD_W-1:0] lft;
    logic [FIELD_W-1:0] rgt;
    logic [VALUE_W-1:0] val;
    logic [VALUE_W-1:0] amt;
  } cmd_t;

  typedef struct {
    logic [RESULT_W-1:0] value;
    logic [FIELD_W-1:0]  index;
  } read_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  brae_item_if   item_bus ();
  brae_result_if res_bus ();
  brae_cfg_if    cfg_bus ();

  batched_range_add_engine_core #(
    .MAX_LEN(LEN_LIMIT),
    .MAX_OPS(OPS_LIMIT)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .items  (item_bus),
    .results(res_bus),
    .cfg    (cfg_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the engine state. Element and operation entries that were
  // never loaded are tracked so that the stimulus never reads or folds them.
  bit [RESULT_W-1:0] shadow_elem     [0:LEN_LIMIT+1];
  bit [FIELD_W-1:0]  shadow_op_lft   [0:OPS_LIMIT];
  bit [FIELD_W-1:0]  shadow_op_rgt   [0:OPS_LIMIT];
  bit [VALUE_W-1:0]  shadow_op_amt   [0:OPS_LIMIT];
  bit [31:0]         shadow_rep_diff [0:OPS_LIMIT+1];
  bit                elem_written    [0:LEN_LIMIT];
  bit                op_written      [0:OPS_LIMIT];
  int                shadow_len = LEN_LIMIT;
  int                shadow_ops = OPS_LIMIT;

  // Reads accepted by the engine whose results have not come back yet.
  read_result_t awaited_reads [$];

  int unsigned fail_count = 0;
  int          idle_cycles = 0;
  bit          src_steady = 1'b0;
  bit          sink_steady = 1'b0;
  int          sink_hold = 0;

  // A written value of zero counts as one, and values above the limit saturate.
  function automatic int limit_reg(int v, int top);
    if (v == 0) return 1;
    return (v > top) ? top : v;
  endfunction

  // The compute pass. Each operation in use is applied over its element range,
  // clipped to the array length, scaled by its repeat count. The count is the
  // running sum of the query difference store and wraps at 32 bits; the store is then cleared.
  function automatic void fold_range_adds();
    bit [31:0]         reps;
    bit [RESULT_W-1:0] add;
    int                hi;
    reps = '0;
    for (int k = 1; k <= shadow_ops; k++) begin
      reps += shadow_rep_diff[k];
      hi = (shadow_op_rgt[k] > shadow_len) ? shadow_len : int'(shadow_op_rgt[k]);
      if (shadow_op_lft[k] != 0 && shadow_op_lft[k] <= hi) begin
        add = 64'(shadow_op_amt[k]) * 64'(reps);
        for (int e = shadow_op_lft[k]; e <= hi; e++) begin
          shadow_elem[e] += add;
        end
      end
    end
    for (int k = 0; k <= OPS_LIMIT + 1; k++) begin
      shadow_rep_diff[k] = '0;
    end
  endfunction

  // Applies one accepted item transaction to the shadow state and records the
  // result that a read must produce.
  function automatic void update_shadow(cmd_t c);
    int           hi;
    read_result_t want;
    case (c.opc)
      OPC_LOAD_ELEM: begin
        if (c.idx >= 1 && c.idx <= shadow_len) begin
          shadow_elem[c.idx]  = 64'(c.val);
          elem_written[c.idx] = 1'b1;
        end
      end
      OPC_LOAD_OP: begin
        if (c.idx >= 1 && c.idx <= shadow_ops) begin
          shadow_op_lft[c.idx] = c.lft;
          shadow_op_rgt[c.idx] = c.rgt;
          shadow_op_amt[c.idx] = c.amt;
          op_written[c.idx]    = 1'b1;
        end
      end
      OPC_QUERY: begin
        hi = (c.rgt > OPS_LIMIT) ? OPS_LIMIT : int'(c.rgt);
        if (c.lft != 0 && c.lft <= hi) begin
          shadow_rep_diff[c.lft]  += 32'd1;
          shadow_rep_diff[hi + 1] -= 32'd1;
        end
      end
      OPC_COMPUTE: fold_range_adds();
      OPC_READ: begin
        want.value = (c.idx >= 1 && c.idx <= shadow_len) ? shadow_elem[c.idx] : '0;
        want.index = c.idx;
        awaited_reads.push_back(want);
      end
      default: ;
    endcase
  endfunction

  // A compute may only run once every element and operation slot in use holds
  // a loaded value.
  function automatic bit can_compute();
    for (int e = 1; e <= shadow_len; e++) begin
      if (!elem_written[e]) return 1'b0;
    end
    for (int k = 1; k <= shadow_ops; k++) begin
      if (!op_written[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Mostly back-to-back or short gaps, with an occasional long one.
  function automatic int pick_gap();
    int r;
    if (src_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Picks an element to read: a loaded one inside the array, or one outside
  // it, which reads as zero. An unloaded element inside the array is never read.
  function automatic int pick_read_index();
    int cand;
    cand = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                      : $urandom_range(1, shadow_len);
    for (int t = 0; t < 8; t++) begin
      if (cand < 1 || cand > shadow_len || elem_written[cand]) return cand;
      cand = $urandom_range(1, shadow_len);
    end
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(shadow_len + 1, 2047);
  endfunction

  // Drives one item, holds it until the engine takes it, then updates the
  // shadow state at the accepting edge. Every call starts right after a
  // rising edge, and valid gets a single assignment in any one time step.
  task automatic send_item(cmd_t c);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid         <= 1'b1;
    item_bus.opcode        <= c.opc;
    item_bus.slot_index    <= c.idx;
    item_bus.range_left    <= c.lft;
    item_bus.range_right   <= c.rgt;
    item_bus.element_value <= c.val;
    item_bus.op_amount     <= c.amt;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    update_shadow(c);
  endtask

  // Field values that an opcode does not use are random, so they toggle too.
  task automatic send_cmd(logic [OPC_W-1:0] opc, int idx, int lft, int rgt,
                          logic [VALUE_W-1:0] val, logic [VALUE_W-1:0] amt);
    cmd_t c;
    c.opc = opc;
    c.idx = FIELD_W'(idx);
    c.lft = FIELD_W'(lft);
    c.rgt = FIELD_W'(rgt);
    c.val = val;
    c.amt = amt;
    send_item(c);
  endtask

  task automatic send_elem(int idx, logic [VALUE_W-1:0] val);
    send_cmd(OPC_LOAD_ELEM, idx, $urandom_range(0, 2047), $urandom_range(0, 2047),
             val, $urandom);
  endtask

  task automatic send_op(int slot, int lft, int rgt, logic [VALUE_W-1:0] amt);
    send_cmd(OPC_LOAD_OP, slot, lft, rgt, $urandom, amt);
  endtask

  task automatic send_query(int lft, int rgt);
    send_cmd(OPC_QUERY, $urandom_range(0, 2047), lft, rgt, $urandom, $urandom);
  endtask

  task automatic send_compute();
    send_cmd(OPC_COMPUTE, $urandom_range(0, 2047), $urandom_range(0, 2047),
             $urandom_range(0, 2047), $urandom, $urandom);
  endtask

  task automatic send_read(int idx);
    send_cmd(OPC_READ, idx, $urandom_range(0, 2047), $urandom_range(0, 2047),
             $urandom, $urandom);
  endtask

  task automatic send_spare(logic [OPC_W-1:0] opc);
    send_cmd(opc, $urandom_range(0, 2047), $urandom_range(0, 2047),
             $urandom_range(0, 2047), $urandom, $urandom);
  endtask

  // Writes one register. The engine is idle whenever this is called.
  task automatic write_reg(logic [CFG_IDX_W-1:0] ri, int data);
    cfg_bus.valid      <= 1'b1;
    cfg_bus.reg_index  <= ri;
    cfg_bus.write_data <= FIELD_W'(data);
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (ri == CFG_ARRAY_LENGTH) begin
      shadow_len = limit_reg(data & 32'h7FF, LEN_LIMIT);
    end else if (ri == CFG_OP_COUNT) begin
      shadow_ops = limit_reg(data & 32'h7FF, OPS_LIMIT);
    end
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Ends a phase: all reads answered, then enough cycles for a compute that
  // may still be walking the memories, since a compute leaves no result.
  task automatic settle();
    item_bus.valid <= 1'b0;
    while (awaited_reads.size() != 0) @(posedge clk);
    repeat (2 * shadow_len + 6 * shadow_ops + OPS_LIMIT + 16) @(posedge clk);
  endtask

  // Register values straight out of reset: both sizes are at their maximum,
  // so the last element and the last operation slot are in use.
  task automatic test_reset_values();
    send_elem(LEN_LIMIT, pick_word());
    send_elem(LEN_LIMIT + 1, pick_word());
    send_op(OPS_LIMIT, 1, LEN_LIMIT, pick_word());
    send_query(1, OPS_LIMIT);
    send_read(LEN_LIMIT);
    send_read(LEN_LIMIT + 1);
    settle();
  endtask

  // A small array with every opcode and every edge of the range rules: loads
  // outside the array or beyond the slot count, operation ranges that run
  // past the end, start at zero or start past the end, queries that saturate
  // or are empty, and reads outside the array.
  task automatic test_directed_ops();
    write_reg(CFG_ARRAY_LENGTH, 4);
    write_reg(CFG_OP_COUNT, 4);
    write_reg(CFG_SPARE, 2047);
    send_elem(1, 32'h0000_0000);
    send_elem(2, 32'hFFFF_FFFF);
    send_elem(3, 32'h8000_0001);
    send_elem(4, 32'h0000_0001);
    send_elem(0, 32'hDEAD_BEEF);
    send_elem(5, 32'hDEAD_BEEF);
    send_elem(2047, 32'hDEAD_BEEF);
    send_op(1, 1, 4, 32'hFFFF_FFFF);
    send_op(2, 3, 2047, 32'd7);
    send_op(3, 0, 2, 32'd5);
    send_op(4, 2047, 3, 32'd9);
    send_op(5, 1, 1, 32'd3);
    send_op(0, 1, 1, 32'd3);
    send_query(1, 4);
    send_query(2, 2047);
    send_query(0, 3);
    send_query(3, 2);
    send_query(2047, 2047);
    for (int o = OPC_SPARE_LO; o <= OPC_SPARE_HI; o++) send_spare(OPC_W'(o));
    send_compute();
    for (int e = 1; e <= 4; e++) send_read(e);
    send_read(0);
    send_read(5);
    send_read(2047);
    settle();
  endtask

  // Register extremes: zero is taken as one, values past the limit saturate,
  // and the exact limit is accepted as written.
  task automatic test_register_limits();
    write_reg(CFG_ARRAY_LENGTH, 0);
    write_reg(CFG_OP_COUNT, 0);
    send_elem(1, pick_word());
    send_op(1, 1, 2047, pick_word());
    send_query(1, 1);
    send_query(1, 2047);
    send_compute();
    send_read(1);
    send_read(2);
    settle();
    write_reg(CFG_ARRAY_LENGTH, 2047);
    write_reg(CFG_OP_COUNT, 2047);
    send_elem(LEN_LIMIT, pick_word());
    send_op(OPS_LIMIT, 2, 3, pick_word());
    send_read(LEN_LIMIT);
    send_read(LEN_LIMIT + 1);
    settle();
    write_reg(CFG_ARRAY_LENGTH, LEN_LIMIT);
    send_read(LEN_LIMIT);
    settle();
  endtask

  // Register value for a random phase: mostly small arrays so that computes
  // stay cheap, sometimes the extremes.
  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(1, 24);
    if (r < 85) return $urandom_range(25, 64);
    if (r < 92) return 0;
    if (r < 96) return 1;
    return $urandom_range(1024, 2047);
  endfunction

  // Random phases. Each picks sizes and, when both are at most 64, loads every element and
  // slot in use so that computes are legal, then runs a random mix of transactions and ends
  // with a compute, if every element and slot in use is loaded, and three reads.
  task automatic test_random_rounds();
    int sent;
    int n;
    int r;
    int lft;
    int rgt;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_ARRAY_LENGTH, pick_size());
        write_reg(CFG_OP_COUNT, pick_size());
      end else begin
        write_reg(CFG_OP_COUNT, pick_size());
        write_reg(CFG_ARRAY_LENGTH, pick_size());
      end
      src_steady = ($urandom_range(0, 3) == 0);

      if (shadow_len <= 64 && shadow_ops <= 64) begin
        for (int e = 1; e <= shadow_len; e++) begin
          if (!elem_written[e]) begin
            send_elem(e, pick_word());
            sent++;
          end
        end
        for (int k = 1; k <= shadow_ops; k++) begin
          if (!op_written[k]) begin
            lft = $urandom_range(1, shadow_len);
            send_op(k, lft, $urandom_range(lft, shadow_len), pick_word());
            sent++;
          end
        end
      end

      n = $urandom_range(10, 40);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 99);
        if (r < 14) begin
          send_elem(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                : $urandom_range(1, shadow_len),
                    pick_word());
        end else if (r < 28) begin
          lft = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                            : $urandom_range(1, shadow_len);
          if (lft >= 1 && lft <= shadow_len && $urandom_range(0, 7) != 0) begin
            rgt = $urandom_range(lft, shadow_len);
          end else begin
            rgt = $urandom_range(0, 2047);
          end
          send_op(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                              : $urandom_range(1, shadow_ops),
                  lft, rgt, pick_word());
        end else if (r < 52) begin
          lft = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                            : $urandom_range(1, shadow_ops);
          if (lft >= 1 && lft <= shadow_ops && $urandom_range(0, 7) != 0) begin
            rgt = $urandom_range(lft, shadow_ops);
          end else begin
            rgt = $urandom_range(0, 2047);
          end
          send_query(lft, rgt);
        end else if (r < 60 && can_compute()) begin
          send_compute();
        end else if (r < 94) begin
          send_read(pick_read_index());
        end else if (r < 97) begin
          // Spare opcodes are ignored by the engine and do not count.
          send_spare(OPC_W'($urandom_range(OPC_SPARE_LO, OPC_SPARE_HI)));
          sent--;
        end else begin
          send_cmd(OPC_W'($urandom_range(OPC_LOAD_ELEM, OPC_QUERY)),
                   $urandom_range(0, 2047), $urandom_range(0, 2047),
                   $urandom_range(0, 2047), $urandom, $urandom);
        end
        sent++;
      end

      if (can_compute()) begin
        send_compute();
        sent++;
      end
      for (int i = 0; i < 3; i++) begin
        send_read(pick_read_index());
        sent++;
      end
      settle();
    end
  endtask

  // The result side is stalled at random: short holds mostly, a few long ones,
  // and stretches with ready held high throughout.
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) sink_steady <= !sink_steady;
    if (rst) begin
      res_bus.ready <= 1'b0;
      sink_hold     <= 0;
    end else if (sink_hold != 0) begin
      res_bus.ready <= 1'b0;
      sink_hold     <= sink_hold - 1;
    end else begin
      res_bus.ready <= 1'b1;
      if (!sink_steady && $urandom_range(0, 99) < 20) begin
        sink_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                 : $urandom_range(1, 3);
      end
    end
  end

  // Every result transaction is matched against the oldest outstanding read.
  always @(posedge clk) begin : check_results
    read_result_t want;
    if (!rst && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      if (awaited_reads.size() == 0) begin
        $error("result with no read outstanding: index %0d value %h",
               res_bus.result_index, res_bus.result_value);
        fail_count++;
      end else begin
        want = awaited_reads.pop_front();
        if (res_bus.result_value !== want.value) begin
          $error("result_value: expected %h, actual %h", want.value, res_bus.result_value);
          fail_count++;
        end
        if (res_bus.result_index !== want.index) begin
          $error("result_index: expected %0d, actual %0d", want.index,
                 res_bus.result_index);
          fail_count++;
        end
      end
    end
  end

  // The run is abandoned when no transaction of any kind completes for a long
  // stretch. The limit sits well above the slowest compute at full size.
  always @(posedge clk) begin
    if ((item_bus.valid === 1'b1 && item_bus.ready === 1'b1) ||
        (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) ||
        (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    item_bus.valid         <= 1'b0;
    item_bus.opcode        <= OPC_LOAD_ELEM;
    item_bus.slot_index    <= '0;
    item_bus.range_left    <= '0;
    item_bus.range_right   <= '0;
    item_bus.element_value <= '0;
    item_bus.op_amount     <= '0;
    cfg_bus.valid          <= 1'b0;
    cfg_bus.reg_index      <= CFG_ARRAY_LENGTH;
    cfg_bus.write_data     <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // The engine clears its repeat-count memory after reset; the first item
    // simply waits for ready, while configuration is taken at once.
    test_reset_values();
    test_directed_ops();
    test_register_limits();
    test_random_rounds();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== batched_range_add_engine_core.f =====
rtl/core/brae_pkg.sv
rtl/core/brae_ifs.sv
rtl/core/brae_op_mac.sv
rtl/core/batched_range_add_engine_core.sv
rtl/core/brae_core_checker.sv
tb/tb_batched_range_add_engine_core.sv
